// ----- rtl/midi_note_message_parser_core_assert.svh -----
// Assertion macros used by the verification checker of the MIDI note parser.
`ifndef MIDI_NOTE_MESSAGE_PARSER_CORE_ASSERT_SVH
`define MIDI_NOTE_MESSAGE_PARSER_CORE_ASSERT_SVH

// Property checked on every rising clock edge outside of reset.
`define MNP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define MNP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/mnp_pkg.sv -----
// Types, constants and helper functions of the MIDI note message parser.
package mnp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned DATA_W = 7;
    localparam int unsigned OUT_TDATA_W = 16;

    // Status byte ranges.
    localparam logic [BYTE_W-1:0] REALTIME_FIRST = 8'hF8;
    localparam logic [BYTE_W-1:0] SYSTEM_FIRST   = 8'hF0;

    // Upper nibbles of channel status bytes.
    typedef enum logic [3:0] {
        KIND_NOTE_OFF   = 4'h8,
        KIND_NOTE_ON    = 4'h9,
        KIND_POLY_PRESS = 4'hA,
        KIND_CONTROL    = 4'hB,
        KIND_PROGRAM    = 4'hC,
        KIND_CHAN_PRESS = 4'hD,
        KIND_PITCH_BEND = 4'hE
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] running_status;
        logic [1:0]        bytes_needed;
        logic [1:0]        byte_position;
        logic [DATA_W-1:0] first_data;
        logic [DATA_W-1:0] second_data;
    } t_parse_state;

    localparam t_parse_state STATE_RESET = '{
        running_status: '0,
        bytes_needed:   '0,
        byte_position:  '0,
        first_data:     '0,
        second_data:    '0
    };

    typedef struct packed {
        logic              emit;
        logic              note_on;
        logic [DATA_W-1:0] key_number;
        logic [DATA_W-1:0] key_velocity;
    } t_note_event;

    // Number of data bytes that follow a channel status byte.
    function automatic logic [1:0] data_count_for(input logic [BYTE_W-1:0] status);
        logic [1:0] count;
        unique case (status[7:4])
            KIND_PROGRAM, KIND_CHAN_PRESS:                       count = 2'd1;
            KIND_NOTE_OFF, KIND_NOTE_ON, KIND_POLY_PRESS,
            KIND_CONTROL, KIND_PITCH_BEND:                       count = 2'd2;
            default:                                             count = 2'd0;
        endcase
        return count;
    endfunction

endpackage

// ----- rtl/midi_note_message_parser_core.sv -----
// Top level of the MIDI note message parser with running status.
//
// The block takes one received MIDI byte per input item and emits a note
// event item when a note-on or note-off message completes. It tracks the
// running status, so repeated data byte pairs after one status byte each
// produce an event. Real-time bytes are ignored, system bytes cancel the
// running status, and data bytes that arrive without a status are dropped.
// A note-on with velocity zero comes out as a note-off, and every note-off
// carries velocity zero. Other channel messages are parsed and produce no
// item; the channel number is not reported. The block accepts one byte in
// every cycle while no event stalls: the parser state loop closes through
// a single decode step between the input register and the state register.
// A byte that completes a note message goes from the input register through
// the decode step into the result register once that register is free.
// The input stage keeps accepting while a finished event waits for the
// consumer; only a byte that would produce a second event stalls there.
module midi_note_message_parser_core
    import mnp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [7:0] rx_byte
    input  logic [BYTE_W-1:0]      i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [6:0] key_number, [13:7] key_velocity, [15:14] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [0] note_on
    output logic [0:0]             o_m_axis_tuser
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    t_parse_state      r_state;
    t_parse_state      n_state;
    t_note_event       w_event;
    logic              w_advance;
    logic              r_out_valid;
    logic              r_note_on;
    logic [DATA_W-1:0] r_key_number;
    logic [DATA_W-1:0] r_key_velocity;

    mnp_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .o_state (n_state),
        .o_event (w_event)
    );

    // The buffered byte moves on unless it makes an event and the result
    // register is still occupied by one the consumer has not taken.
    assign w_advance = r_in_valid && (!w_event.emit || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_advance) begin
                r_state <= n_state;
            end
            if (w_advance && w_event.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (w_advance && w_event.emit) begin
            r_note_on      <= w_event.note_on;
            r_key_number   <= w_event.key_number;
            r_key_velocity <= w_event.key_velocity;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = {{(OUT_TDATA_W - 2*DATA_W){1'b0}}, r_key_velocity, r_key_number};
    assign o_m_axis_tuser[0] = r_note_on;

endmodule

// ----- rtl/mnp_decode.sv -----
// Combinational step of the running status parser: next state and note event.
module mnp_decode
    import mnp_pkg::*;
(
    input  t_parse_state      i_state,
    input  logic [BYTE_W-1:0] i_byte,
    output t_parse_state      o_state,
    output t_note_event       o_event
);

    logic [1:0] w_pos_inc;
    logic [3:0] w_kind;

    assign w_pos_inc = i_state.byte_position + 2'd1;
    assign w_kind    = i_state.running_status[7:4];

    always_comb begin
        o_state = i_state;
        o_event = '0;
        if (i_byte[7]) begin
            priority if (i_byte >= REALTIME_FIRST) begin
                // Real-time bytes leave everything untouched.
            end else if (i_byte >= SYSTEM_FIRST) begin
                o_state.running_status = '0;
                o_state.bytes_needed   = '0;
                o_state.byte_position  = '0;
            end else begin
                o_state.running_status = i_byte;
                o_state.bytes_needed   = data_count_for(i_byte);
                o_state.byte_position  = '0;
            end
        end else if (i_state.running_status != '0 && i_state.bytes_needed != '0) begin
            if (i_state.byte_position == 2'd0) begin
                o_state.first_data = i_byte[DATA_W-1:0];
            end else if (i_state.byte_position == 2'd1) begin
                o_state.second_data = i_byte[DATA_W-1:0];
            end
            if (w_pos_inc < i_state.bytes_needed) begin
                o_state.byte_position = w_pos_inc;
            end else begin
                o_state.byte_position = '0;
                o_event.key_number    = o_state.first_data;
                if (w_kind == KIND_NOTE_ON && i_state.bytes_needed >= 2'd2
                        && o_state.second_data != '0) begin
                    o_event.emit         = 1'b1;
                    o_event.note_on      = 1'b1;
                    o_event.key_velocity = o_state.second_data;
                end else if (w_kind == KIND_NOTE_ON || w_kind == KIND_NOTE_OFF) begin
                    o_event.emit = 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/mnp_checker.sv -----
// Port-level checker for the MIDI note message parser and its bind.
`include "midi_note_message_parser_core_assert.svh"

module mnp_checker
    import mnp_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [BYTE_W-1:0]      i_s_axis_tdata,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [0:0]             o_m_axis_tuser
);

    logic [DATA_W-1:0] w_velocity;
    logic              w_in_seen;

    assign w_velocity = o_m_axis_tdata[2*DATA_W-1:DATA_W];
    assign w_in_seen  = i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tdata != '1);

    `MNP_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled event changed")
    `MNP_ASSERT(a_off_zero_vel, o_m_axis_tvalid && !o_m_axis_tuser[0] |-> w_velocity == '0, "note-off with nonzero velocity")
    `MNP_ASSERT(a_on_nonzero_vel, o_m_axis_tvalid && o_m_axis_tuser[0] |-> w_velocity != '0, "note-on with zero velocity")
    `MNP_ASSERT(a_pad_zero, o_m_axis_tvalid |-> o_m_axis_tdata[OUT_TDATA_W-1:2*DATA_W] == '0, "padding bits set")
    `MNP_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_m_axis_tvalid && !w_in_seen || o_s_axis_tready, "output valid after reset")

endmodule

bind midi_note_message_parser_core mnp_checker u_mnp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
